@@ rtl/pwmmf_pkg.sv @@
// Shared constants for the PWM input measurement and display formatting block.
package pwmmf_pkg;
  localparam int unsigned CLK_W = 27;
  localparam int unsigned PRESC_W = 16;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned DD_STAGES = 4;
  localparam int unsigned DD_STEPS = 7;
  localparam int unsigned DD_BIN_W = DD_STAGES * DD_STEPS;

  localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(64000000);
  localparam logic [PRESC_W-1:0] PRESC_RESET = PRESC_W'(1);
  localparam logic [CLK_W-1:0] BASE_RESET = CLK_W'(32000000);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h10;

  localparam logic REG_CORE_CLOCK = 1'b0;
  localparam logic REG_PRESCALE = 1'b1;
endpackage

@@ rtl/pwmmf_basediv.sv @@
// Iterative divider that derives the timer tick rate from the clock and prescaler.
module pwmmf_basediv
  import pwmmf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CLK_W-1:0] clock_i,
  input  logic [PRESC_W:0] divisor_i,
  output logic             busy_o,
  output logic [CLK_W-1:0] base_o
);
  logic             busy_q, busy_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [PRESC_W:0] rem_q, rem_d;
  logic [CLK_W-1:0] num_q, num_d;
  logic [PRESC_W:0] div_q, div_d;
  logic [PRESC_W+1:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    div_d = div_q;
    trial = {rem_q, num_q[CLK_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 5'(CLK_W - 1);
      rem_d = '0;
      num_d = clock_i;
      div_d = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
        num_d = {num_q[CLK_W-2:0], 1'b1};
      end else begin
        num_d = {num_q[CLK_W-2:0], 1'b0};
      end
      rem_d = trial[PRESC_W:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      num_q <= BASE_RESET;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign base_o = num_q;
endmodule

@@ rtl/pwmmf_pipe.sv @@
// Pipelined datapath: duty and frequency division, saturation and digit conversion.
module pwmmf_pipe
  import pwmmf_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned DISPLAY_DIGITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    take_i,
  input  logic [COUNTER_BITS-1:0] period_i,
  input  logic [COUNTER_BITS-1:0] high_i,
  input  logic [CLK_W-1:0]        base_i,
  output logic                    valid_o,
  output logic [DUTY_W-1:0]       duty_o,
  output logic [CLK_W-1:0]        freq_o,
  output logic [4*CHAR_W-1:0]     chars_o,
  output logic                    ovf_o,
  output logic                    clip_o,
  output logic                    pzero_o
);
  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned NF = CLK_W;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned r;
    r = 1;
    for (int unsigned k = 0; k < n; k++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam logic [CLK_W-1:0] LIMIT = CLK_W'(pow10(DISPLAY_DIGITS) - 1);

  typedef struct packed {
    logic [CB-1:0]     per;
    logic [CB-1:0]     frem;
    logic [CLK_W-1:0]  fnum;
    logic [CB-1:0]     drem;
    logic [DUTY_W-1:0] dnum;
    logic              clip;
    logic              pzero;
  } front_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [CLK_W-1:0]    freq;
    logic [DD_BIN_W-1:0] bin;
    logic [15:0]         bcd;
    logic [3:0]          blank;
    logic                ovf;
    logic                clip;
    logic                pzero;
  } back_t;

  function automatic front_t div_step(input front_t a, input logic do_duty);
    front_t      r;
    logic [CB:0] t;
    logic [CB:0] u;
    r = a;
    t = {a.frem, a.fnum[CLK_W-1]};
    if (t >= {1'b0, a.per}) begin
      t = t - {1'b0, a.per};
      r.fnum = {a.fnum[CLK_W-2:0], 1'b1};
    end else begin
      r.fnum = {a.fnum[CLK_W-2:0], 1'b0};
    end
    r.frem = t[CB-1:0];
    if (do_duty) begin
      u = {a.drem, a.dnum[DUTY_W-1]};
      if (u >= {1'b0, a.per}) begin
        u = u - {1'b0, a.per};
        r.dnum = {a.dnum[DUTY_W-2:0], 1'b1};
      end else begin
        r.dnum = {a.dnum[DUTY_W-2:0], 1'b0};
      end
      r.drem = u[CB-1:0];
    end
    return r;
  endfunction

  function automatic back_t dd_steps(input back_t a);
    back_t r;
    r = a;
    for (int unsigned s = 0; s < DD_STEPS; s++) begin
      for (int unsigned d = 0; d < 4; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[14:0], r.bin[DD_BIN_W-1]};
      r.bin = {r.bin[DD_BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  front_t fa_q [NF+1];
  logic   va_q [NF+1];
  back_t  fb_q [DD_STAGES+1];
  logic   vb_q [DD_STAGES+1];

  logic [CB+DUTY_W-1:0] prod;
  front_t               fa_in;
  back_t                fb_in;
  logic [CLK_W-1:0]     shown;

  always_comb begin
    prod = {{DUTY_W{1'b0}}, high_i} * (CB + DUTY_W)'(100);
    fa_in.per = period_i;
    fa_in.frem = '0;
    fa_in.fnum = base_i;
    fa_in.drem = prod[CB+DUTY_W-1:DUTY_W];
    fa_in.dnum = prod[DUTY_W-1:0];
    fa_in.clip = (high_i > period_i);
    fa_in.pzero = (period_i == '0);
  end

  always_comb begin
    fb_in.pzero = fa_q[NF].pzero;
    fb_in.clip = fa_q[NF].clip & ~fa_q[NF].pzero;
    fb_in.freq = fa_q[NF].pzero ? '0 : fa_q[NF].fnum;
    if (fa_q[NF].pzero) begin
      fb_in.duty = '0;
    end else if (fa_q[NF].clip) begin
      fb_in.duty = DUTY_FULL;
    end else begin
      fb_in.duty = fa_q[NF].dnum;
    end
    fb_in.ovf = (fb_in.freq > LIMIT);
    shown = fb_in.ovf ? LIMIT : fb_in.freq;
    for (int unsigned p = 0; p < 4; p++) begin
      fb_in.blank[p] = (p >= DISPLAY_DIGITS) || ({1'b0, shown} < (CLK_W + 1)'(pow10(p)))
                       || (shown == '0);
    end
    fb_in.bin = {{(DD_BIN_W - CLK_W){1'b0}}, shown};
    fb_in.bcd = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k <= NF; k++) begin
        va_q[k] <= 1'b0;
      end
      for (int unsigned k = 0; k <= DD_STAGES; k++) begin
        vb_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      va_q[0] <= take_i;
      for (int unsigned k = 1; k <= NF; k++) begin
        va_q[k] <= va_q[k-1];
      end
      vb_q[0] <= va_q[NF];
      for (int unsigned k = 1; k <= DD_STAGES; k++) begin
        vb_q[k] <= vb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q[0] <= fa_in;
      for (int unsigned k = 1; k <= NF; k++) begin
        fa_q[k] <= div_step(fa_q[k-1], k <= DUTY_W);
      end
      fb_q[0] <= fb_in;
      for (int unsigned k = 1; k <= DD_STAGES; k++) begin
        fb_q[k] <= dd_steps(fb_q[k-1]);
      end
    end
  end

  always_comb begin
    for (int unsigned p = 0; p < 4; p++) begin
      chars_o[CHAR_W*p +: CHAR_W] = fb_q[DD_STAGES].blank[p] ? BLANK_CODE :
          ASCII_ZERO + {4'b0, fb_q[DD_STAGES].bcd[4*p +: 4]};
    end
  end

  assign valid_o = vb_q[DD_STAGES];
  assign duty_o = fb_q[DD_STAGES].duty;
  assign freq_o = fb_q[DD_STAGES].freq;
  assign ovf_o = fb_q[DD_STAGES].ovf;
  assign clip_o = fb_q[DD_STAGES].clip;
  assign pzero_o = fb_q[DD_STAGES].pzero;
endmodule

@@ rtl/pwm_input_measure_and_format_top.sv @@
// Top level: register port, tick rate divider and the measurement pipeline.
// An accepted capture moves through the division registers, then the digit conversion registers.
// Takes one capture per cycle unless the output stalls, with 27 one-bit division stages.
// A register write blocks new captures while the tick rate is recomputed.
// Reset clears all valid bits and loads the register reset values with their tick rate.
module pwm_input_measure_and_format_top
  import pwmmf_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned DISPLAY_DIGITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COUNTER_BITS-1:0] period_count_i,
  input  logic [COUNTER_BITS-1:0] high_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DUTY_W-1:0]       duty_percent_o,
  output logic [CLK_W-1:0]        frequency_hz_o,
  output logic [CHAR_W-1:0]       digit_thousands_o,
  output logic [CHAR_W-1:0]       digit_hundreds_o,
  output logic [CHAR_W-1:0]       digit_tens_o,
  output logic [CHAR_W-1:0]       digit_ones_o,
  output logic                    display_overflow_o,
  output logic                    duty_clipped_o,
  output logic                    period_zero_o
);
  logic [CLK_W-1:0]   clock_q;
  logic [PRESC_W-1:0] presc_q;
  logic               start_q;
  logic               wr;
  logic               busy;
  logic [CLK_W-1:0]   base;
  logic               en;
  logic [4*CHAR_W-1:0] chars;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= CLOCK_RESET;
      presc_q <= PRESC_RESET;
      start_q <= 1'b0;
    end else begin
      start_q <= wr;
      if (wr) begin
        unique case (paddr[2])
          REG_CORE_CLOCK: clock_q <= pwdata[CLK_W-1:0];
          REG_PRESCALE:   presc_q <= pwdata[PRESC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CORE_CLOCK: prdata = {{(32 - CLK_W){1'b0}}, clock_q};
      REG_PRESCALE:   prdata = {{(32 - PRESC_W){1'b0}}, presc_q};
      default:        prdata = '0;
    endcase
  end

  pwmmf_basediv u_basediv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .clock_i   (clock_q),
    .divisor_i ({1'b0, presc_q} + (PRESC_W + 1)'(1)),
    .busy_o    (busy),
    .base_o    (base)
  );

  assign en = ~out_valid_o | out_ready_i;
  assign in_ready_o = en & ~busy & ~start_q;

  pwmmf_pipe #(
    .COUNTER_BITS   (COUNTER_BITS),
    .DISPLAY_DIGITS (DISPLAY_DIGITS)
  ) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .take_i   (in_valid_i & in_ready_o),
    .period_i (period_count_i),
    .high_i   (high_count_i),
    .base_i   (base),
    .valid_o  (out_valid_o),
    .duty_o   (duty_percent_o),
    .freq_o   (frequency_hz_o),
    .chars_o  (chars),
    .ovf_o    (display_overflow_o),
    .clip_o   (duty_clipped_o),
    .pzero_o  (period_zero_o)
  );

  assign digit_ones_o = chars[CHAR_W-1:0];
  assign digit_tens_o = chars[2*CHAR_W-1:CHAR_W];
  assign digit_hundreds_o = chars[3*CHAR_W-1:2*CHAR_W];
  assign digit_thousands_o = chars[4*CHAR_W-1:3*CHAR_W];

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy || start_q) |-> !in_ready_o)
    else $error("Capture accepted while the tick rate was being recomputed.");

  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period_zero_o) |-> (frequency_hz_o == '0 && duty_percent_o == '0
      && digit_ones_o == BLANK_CODE))
    else $error("Zero period produced a nonzero result.");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && duty_clipped_o) |-> (duty_percent_o == DUTY_FULL))
    else $error("Clipped duty is not full scale.");

  a_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> start_q ##1 busy)
    else $error("Register write did not restart the tick rate divider.");
endmodule

@@ tb/sv/tb_pwm_input_measure_and_format_top.sv @@
// Testbench for the PWM input measurement and display formatting block.
`timescale 1ns / 100ps

class pwm_capture_board;
  typedef struct packed {
    logic [6:0]  duty;
    logic [26:0] freq;
    logic [7:0]  d3, d2, d1, d0;
    logic        ovf, clip, pzero;
  } capture_result_t;

  logic [26:0] core_clock_hz = 27'd64000000;
  logic [15:0] prescale = 16'd1;
  capture_result_t pending_results[$];
  int mismatches = 0;

  function capture_result_t measure(logic [15:0] period, logic [15:0] high);
    capture_result_t r;
    longint unsigned shown;
    longint unsigned f;
    logic [7:0] chars[4];
    r = '0;
    if (period == 0) begin
      r.pzero = 1'b1;
    end else begin
      r.duty = 7'((64'(high) * 100) / period);
      if (high > period) begin
        r.clip = 1'b1;
        r.duty = 7'd100;
      end
      f = (64'(core_clock_hz) / (64'(prescale) + 1)) / period;
      r.freq = f[26:0];
    end
    shown = r.freq;
    if (shown > 9999) begin
      shown = 9999;
      r.ovf = 1'b1;
    end
    for (int p = 0; p < 4; p++) begin
      if (shown != 0) begin
        chars[p] = 8'h30 + 8'(shown % 10);
        shown = shown / 10;
      end else begin
        chars[p] = 8'h10;
      end
    end
    r.d0 = chars[0];
    r.d1 = chars[1];
    r.d2 = chars[2];
    r.d3 = chars[3];
    return r;
  endfunction

  function void note_capture(logic [15:0] period, logic [15:0] high);
    pending_results.push_back(measure(period, high));
  endfunction

  function void check_result(capture_result_t got);
    capture_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result %h", got);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch: duty %0d/%0d freq %0d/%0d digits %h%h%h%h/%h%h%h%h flags %b%b%b/%b%b%b",
                 want.duty, got.duty, want.freq, got.freq, want.d3, want.d2, want.d1,
                 want.d0, got.d3, got.d2, got.d1, got.d0, want.ovf, want.clip,
                 want.pzero, got.ovf, got.clip, got.pzero);
      end
    end
  endfunction
endclass

module tb_pwm_input_measure_and_format_top;
  import pwmmf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] period_count_i = '0, high_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DUTY_W-1:0] duty_percent_o;
  logic [CLK_W-1:0] frequency_hz_o;
  logic [CHAR_W-1:0] digit_thousands_o, digit_hundreds_o, digit_tens_o, digit_ones_o;
  logic display_overflow_o, duty_clipped_o, period_zero_o;

  pwm_capture_board board = new();
  int cycles = 0;
  bit long_hold = 1'b0;

  pwm_input_measure_and_format_top u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) board.note_capture(period_count_i, high_count_i);
    if (out_valid_o && out_ready_i) begin
      board.check_result({duty_percent_o, frequency_hz_o, digit_thousands_o,
                          digit_hundreds_o, digit_tens_o, digit_ones_o,
                          display_overflow_o, duty_clipped_o, period_zero_o});
    end
  end

  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 4) == 0) w = 0;
      if (w == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
        repeat (w) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_register(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_CORE_CLOCK) board.core_clock_hz = value[26:0];
    else board.prescale = value[15:0];
  endtask

  task automatic send_capture(input logic [15:0] period, input logic [15:0] high,
                              input bit pace);
    int gap;
    gap = (pace && $urandom_range(0, 2) != 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    period_count_i <= period;
    high_count_i <= high;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_phase(input int count, input bit pace);
    logic [15:0] p, h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: p = 16'($urandom_range(1, 20));
        1: p = 16'($urandom_range(0, 3));
        default: p = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: h = 16'($urandom);
        1: h = p + 16'($urandom_range(0, 2));
        default: h = (p == 0) ? 16'($urandom) : 16'($urandom_range(0, p));
      endcase
      send_capture(p, h, pace);
    end
  endtask

  initial begin
    logic [31:0] clocks[6] = '{32'd72000000, 32'd1, 32'd0, 32'd10000, 32'hFFFFFFFF, 32'd48000000};
    logic [31:0] prescales[6] = '{32'd0, 32'd65535, 32'd0, 32'd0, 32'd7, 32'd35999};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (40) @(negedge clk_i);
    send_capture(16'd0, 16'd0, 1'b0);
    send_capture(16'd0, 16'hFFFF, 1'b0);
    send_capture(16'hFFFF, 16'hFFFF, 1'b0);
    send_capture(16'hFFFF, 16'd0, 1'b0);
    send_capture(16'd1, 16'hFFFF, 1'b0);
    send_capture(16'd1, 16'd1, 1'b0);
    send_capture(16'd3200, 16'd1600, 1'b0);
    send_capture(16'd3201, 16'd3202, 1'b0);
    send_capture(16'd32000, 16'd1, 1'b0);
    send_capture(16'd320, 16'd3, 1'b0);
    send_capture(16'hAAAA, 16'h5555, 1'b0);
    send_capture(16'h5555, 16'hAAAA, 1'b0);
    drain();
    write_register(REG_PRESCALE, 32'd0);
    write_register(REG_CORE_CLOCK, 32'd0);
    send_capture(16'd5, 16'd2, 1'b0);
    send_capture(16'd0, 16'd2, 1'b0);
    drain();
    long_hold = 1'b1;
    random_phase(400, 1'b0);
    for (int k = 0; k < 6; k++) begin
      drain();
      write_register(REG_CORE_CLOCK, clocks[k]);
      write_register(REG_PRESCALE, prescales[k]);
      random_phase(150, k[0]);
    end
    drain();
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
